>>> hdl/tadc_pkg.sv
// ----------------------------------------------------------------------------
// Tilt axis drive control package
// Shared item types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package tadc_pkg;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_GAIN      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DRIVE       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWN_DRIVE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UP_DRIVE        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UP_TRAVEL_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_TO_TICKS  = 3'd5;

   localparam logic [14:0]        ERROR_GAIN_RST      = 15'd1638;
   localparam logic [14:0]        MIN_DRIVE_RST       = 15'd819;
   localparam logic signed [15:0] DOWN_DRIVE_RST      = 16'sd3277;
   localparam logic signed [15:0] UP_DRIVE_RST        = -16'sd8192;
   localparam logic signed [15:0] UP_TRAVEL_LIMIT_RST = -16'sd60;
   localparam logic signed [15:0] PITCH_TO_TICKS_RST  = 16'sd1157;

   localparam int DRIVE_ONE = 16384;

   // retarget divides by 256000 = 2^11 * 125
   localparam int PROD_W         = 34;
   localparam int RETARGET_SHIFT = 11;
   localparam int QHI_W          = PROD_W - RETARGET_SHIFT;
   localparam int DIV_LEN        = 125;
   localparam int DIV_BIAS       = 16778;     // lifts the high part above zero
   localparam int DIV_SHIFT      = 30;
   localparam int DIV_RECIP      = 8589934;   // floor(2^30 / 125)
   localparam int RECIP_W        = 24;
   localparam int QUOT_W         = 17;

   typedef struct packed {
      logic signed [15:0] tilt_position;
      logic               down_button;
      logic               up_button;
      logic               retarget;
   } ctl_type;

   typedef struct packed {
      ctl_type            ctl;
      logic signed [17:0] pitch_offset;
   } req_type;

   typedef struct packed {
      ctl_type            ctl;
      logic signed [15:0] target;
   } tgt_type;

   typedef struct packed {
      logic               use_err;
      logic signed [16:0] err;
      logic signed [15:0] manual;
   } drv_type;

   typedef struct packed {
      logic [14:0]        error_gain;
      logic [14:0]        min_drive;
      logic signed [15:0] down_drive;
      logic signed [15:0] up_drive;
      logic signed [15:0] up_travel_limit;
      logic signed [15:0] pitch_to_ticks;
   } cfg_type;

endpackage

>>> hdl/tadc_target_pipe.sv
// ----------------------------------------------------------------------------
// Retarget pipeline
// Computes trunc(count + offset * ticks / 256000), saturated to 16 bits.
// ----------------------------------------------------------------------------
module tadc_target_pipe (
   input  logic              clock,
   input  logic              reset,
   input  tadc_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  tadc_pkg::req_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output tadc_pkg::tgt_type out_item
);

   typedef struct packed {
      tadc_pkg::ctl_type                   ctl;
      logic signed [tadc_pkg::PROD_W-1:0]  prod;
   } s2_type;

   typedef struct packed {
      tadc_pkg::ctl_type                   ctl;
      logic [tadc_pkg::QHI_W-1:0]          x;
      logic [tadc_pkg::QUOT_W-1:0]         q0;
      logic                                low_nz;
   } s3_type;

   localparam int RECIP_PROD_W = tadc_pkg::QHI_W + tadc_pkg::RECIP_W;

   tadc_pkg::req_type s1_ff;
   s2_type            s2_ff, s2_in;
   s3_type            s3_ff, s3_in;
   tadc_pkg::tgt_type s4_ff, s4_in;
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic              rdy1, rdy2, rdy3, rdy4;

   logic [tadc_pkg::QHI_W-1:0]        x_c;
   logic [RECIP_PROD_W-1:0]           recip_prod;
   logic [7:0]                        low_mul, rem0, rem_c;
   logic [tadc_pkg::QUOT_W-1:0]       q_c;
   logic signed [17:0]                quot, sum, adj;
   logic                              nz;

   always_comb begin
      rdy4     = !v4_ff || out_ready;
      rdy3     = !v3_ff || rdy4;
      rdy2     = !v2_ff || rdy3;
      rdy1     = !v1_ff || rdy2;
      in_ready = rdy1;
   end

   // stage 1: offset times ticks per degree
   always_comb begin
      s2_in.ctl  = s1_ff.ctl;
      s2_in.prod = tadc_pkg::PROD_W'(s1_ff.pitch_offset) *
                   tadc_pkg::PROD_W'(cfg.pitch_to_ticks);
   end

   // stage 2: floor divide the high part by 125 through a reciprocal
   always_comb begin
      x_c = tadc_pkg::QHI_W'(s2_ff.prod[tadc_pkg::PROD_W-1:tadc_pkg::RETARGET_SHIFT]) +
            tadc_pkg::QHI_W'(tadc_pkg::DIV_BIAS * tadc_pkg::DIV_LEN);
      recip_prod = RECIP_PROD_W'(x_c) * RECIP_PROD_W'(tadc_pkg::DIV_RECIP);
      s3_in.ctl    = s2_ff.ctl;
      s3_in.x      = x_c;
      s3_in.q0     = recip_prod[tadc_pkg::DIV_SHIFT +: tadc_pkg::QUOT_W];
      s3_in.low_nz = |s2_ff.prod[tadc_pkg::RETARGET_SHIFT-1:0];
   end

   // stage 3: quotient correction, truncation toward zero, saturation
   always_comb begin
      low_mul = 8'(s3_ff.q0[7:0] * 8'(tadc_pkg::DIV_LEN));
      rem0    = s3_ff.x[7:0] - low_mul;
      if (rem0 >= 8'(tadc_pkg::DIV_LEN)) begin
         q_c   = s3_ff.q0 + 1'b1;
         rem_c = rem0 - 8'(tadc_pkg::DIV_LEN);
      end else begin
         q_c   = s3_ff.q0;
         rem_c = rem0;
      end
      nz   = (rem_c != 8'd0) || s3_ff.low_nz;
      quot = signed'(18'(q_c)) - 18'(tadc_pkg::DIV_BIAS);
      sum  = 18'(s3_ff.ctl.tilt_position) + quot;
      adj  = (sum < 18'sd0 && nz) ? sum + 18'sd1 : sum;
      s4_in.ctl = s3_ff.ctl;
      if (adj > 18'sd32767) begin
         s4_in.target = 16'sh7fff;
      end else if (adj < -18'sd32768) begin
         s4_in.target = -16'sh8000;
      end else begin
         s4_in.target = 16'(adj);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && rdy1) s1_ff <= in_item;
      if (v1_ff && rdy2)    s2_ff <= s2_in;
      if (v2_ff && rdy3)    s3_ff <= s3_in;
      if (v3_ff && rdy4)    s4_ff <= s4_in;
   end

   assign out_valid = v4_ff;
   assign out_item  = s4_ff;

endmodule

>>> hdl/tadc_hold_ctrl.sv
// ----------------------------------------------------------------------------
// Hold target control
// Keeps the hold target and button levels, picks manual or closed-loop drive.
// ----------------------------------------------------------------------------
module tadc_hold_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  tadc_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  tadc_pkg::tgt_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output tadc_pkg::drv_type out_item
);

   logic signed [15:0] hold_ff, hold_in;
   logic               last_up_ff, last_down_ff;
   logic               valid_ff;
   tadc_pkg::drv_type  drv_ff, drv_in;
   logic signed [15:0] pos, tgt;
   logic               up, down, release_edge, fire;

   assign in_ready = !valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      pos  = in_item.ctl.tilt_position;
      up   = in_item.ctl.up_button;
      down = in_item.ctl.down_button;
      tgt  = in_item.ctl.retarget ? in_item.target : hold_ff;
      if (up || down) tgt = '0;

      drv_in.use_err = (tgt != 16'sd0);
      drv_in.err     = 17'(tgt) - 17'(pos);
      if (up) begin
         drv_in.manual = (pos < cfg.up_travel_limit) ? 16'sd0 : cfg.up_drive;
      end else if (down) begin
         drv_in.manual = cfg.down_drive;
      end else begin
         drv_in.manual = 16'sd0;
      end

      release_edge = (!up && last_up_ff) || (!down && last_down_ff);
      hold_in      = release_edge ? pos : tgt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= '0;
         last_up_ff   <= 1'b0;
         last_down_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         if (fire) begin
            hold_ff      <= hold_in;
            last_up_ff   <= up;
            last_down_ff <= down;
         end
         if (in_ready) valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) drv_ff <= drv_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = drv_ff;

   a_button_clears: assert property (@(posedge clock) disable iff (reset)
      fire && (up || down) && !release_edge |=> hold_ff == 16'sd0)
      else $error("pressed button left a hold target");

   a_idle_keeps: assert property (@(posedge clock) disable iff (reset)
      fire && !up && !down && !in_item.ctl.retarget && !last_up_ff && !last_down_ff
      |=> $stable(hold_ff))
      else $error("hold target moved without cause");

endmodule

>>> hdl/tadc_drive_out.sv
// ----------------------------------------------------------------------------
// Drive output stage
// Proportional term plus signed minimum (or manual drive), saturation, result register.
// ----------------------------------------------------------------------------
module tadc_drive_out (
   input  logic               clock,
   input  logic               reset,
   input  tadc_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  tadc_pkg::drv_type  in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [15:0] drive
);

   localparam int SUM_W = 35;

   logic               valid_ff;
   logic signed [15:0] drive_ff, drive_in;
   logic signed [SUM_W-1:0] prod, min_term, total;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      prod = SUM_W'(in_item.err) * SUM_W'(signed'({1'b0, cfg.error_gain}));
      if (in_item.err > 17'sd0) begin
         min_term = SUM_W'(signed'({1'b0, cfg.min_drive}));
      end else if (in_item.err < 17'sd0) begin
         min_term = -SUM_W'(signed'({1'b0, cfg.min_drive}));
      end else begin
         min_term = '0;
      end
      total = in_item.use_err ? prod + min_term : SUM_W'(in_item.manual);
      if (total > SUM_W'(tadc_pkg::DRIVE_ONE)) begin
         drive_in = 16'(tadc_pkg::DRIVE_ONE);
      end else if (total < -SUM_W'(tadc_pkg::DRIVE_ONE)) begin
         drive_in = -16'(tadc_pkg::DRIVE_ONE);
      end else begin
         drive_in = 16'(total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) drive_ff <= drive_in;
   end

   assign out_valid = valid_ff;
   assign drive     = drive_ff;

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (drive <= 16'sd16384) && (drive >= -16'sd16384))
      else $error("drive outside full scale");

endmodule

>>> hdl/tilt_axis_drive_control_core.sv
// ----------------------------------------------------------------------------
// Tilt axis drive control core
// One encoder sample in, one Q1.14 motor drive command out.
//
// req_ channel: one item per control tick (count, buttons, retarget,
// pitch offset). rsp_ channel: one drive item per request item, in order.
// csr_ port: register writes, always ready; write only while idle.
// Throughput: one item per cycle while rsp_ does not stall, set by the
// pipeline registers (input, offset multiply, reciprocal divide,
// correction, hold target, drive). The hold target register is updated
// in order in the hold target stage. A stalled rsp_ side fills the
// stages one by one; empty stages keep accepting until the pipeline is
// full, then req_tready drops. Reset: registers return to their
// defaults, no hold target, button levels low, pipeline empty.
// ----------------------------------------------------------------------------
module tilt_axis_drive_control_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [15:0] tilt_position, [16] down_button, [17] up_button,
   // [18] retarget, [36:19] pitch_offset, [39:37] zero
   input  logic [39:0]                      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [15:0] drive
   output logic [15:0]                      rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tadc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_data
);

   tadc_pkg::cfg_type cfg_ff;
   tadc_pkg::req_type req_item;
   tadc_pkg::tgt_type tgt_item;
   tadc_pkg::drv_type drv_item;
   logic              tgt_valid, tgt_ready, drv_valid, drv_ready;
   logic signed [15:0] drive;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.error_gain      <= tadc_pkg::ERROR_GAIN_RST;
         cfg_ff.min_drive       <= tadc_pkg::MIN_DRIVE_RST;
         cfg_ff.down_drive      <= tadc_pkg::DOWN_DRIVE_RST;
         cfg_ff.up_drive        <= tadc_pkg::UP_DRIVE_RST;
         cfg_ff.up_travel_limit <= tadc_pkg::UP_TRAVEL_LIMIT_RST;
         cfg_ff.pitch_to_ticks  <= tadc_pkg::PITCH_TO_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tadc_pkg::CSR_ERROR_GAIN:      cfg_ff.error_gain      <= csr_data[14:0];
            tadc_pkg::CSR_MIN_DRIVE:       cfg_ff.min_drive       <= csr_data[14:0];
            tadc_pkg::CSR_DOWN_DRIVE:      cfg_ff.down_drive      <= csr_data;
            tadc_pkg::CSR_UP_DRIVE:        cfg_ff.up_drive        <= csr_data;
            tadc_pkg::CSR_UP_TRAVEL_LIMIT: cfg_ff.up_travel_limit <= csr_data;
            tadc_pkg::CSR_PITCH_TO_TICKS:  cfg_ff.pitch_to_ticks  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      req_item.ctl.tilt_position = req_tdata[15:0];
      req_item.ctl.down_button   = req_tdata[16];
      req_item.ctl.up_button     = req_tdata[17];
      req_item.ctl.retarget      = req_tdata[18];
      req_item.pitch_offset      = req_tdata[36:19];
   end

   tadc_target_pipe u_target (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (tgt_valid),
      .out_ready (tgt_ready),
      .out_item  (tgt_item)
   );

   tadc_hold_ctrl u_hold (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (tgt_valid),
      .in_ready  (tgt_ready),
      .in_item   (tgt_item),
      .out_valid (drv_valid),
      .out_ready (drv_ready),
      .out_item  (drv_item)
   );

   tadc_drive_out u_drive (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (drv_valid),
      .in_ready  (drv_ready),
      .in_item   (drv_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .drive     (drive)
   );

   assign rsp_tdata = drive;

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with result stage empty");

endmodule
